// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL module; all sample on clk and drop out during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a same-cycle implication; the consequent may carry a ## delay.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) else $error(msg);

// Check an implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/psgcap_pkg.sv =====
// Shared types and constants for the sound register capture block.
package psgcap_pkg;

  typedef enum logic [1:0] {
    STYLE_UNDECIDED = 2'd0,
    STYLE_SINGLE    = 2'd1,
    STYLE_LATCH     = 2'd2
  } port_style_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_SEND
  } dump_state_t;

  // Configuration register indexes
  localparam logic CFG_FORCE_LATCH = 1'b0;
  localparam logic CFG_FRAME_LIMIT = 1'b1;

  localparam logic [14:0] FRAME_LIMIT_RESET = 15'd9000;

  // Port decode
  localparam logic [7:0] PORT_LO_DATA   = 8'hfd;
  localparam logic [7:0] PORT_LO_LOCK   = 8'hfe;
  localparam logic [7:0] PORT_HI_SELECT = 8'hff;
  localparam logic [7:0] PORT_HI_WRITE  = 8'hbf;
  localparam logic [7:0] PORT_HI_CTRL   = 8'hf6;
  localparam logic [7:0] PORT_HI_LATCH  = 8'hf4;
  localparam logic [1:0] TOP_SELECT     = 2'b11;
  localparam logic [1:0] TOP_WRITE      = 2'b10;

  // Frame dump layout
  localparam logic [3:0] DUMP_REGS = 4'd14;
  localparam logic [3:0] DUMP_LAST = 4'd15;

  typedef struct packed {
    port_style_t style;
    logic [3:0]  sel;
    logic [7:0]  latch;
    logic        mem_we;
    logic [3:0]  mem_addr;
    logic [7:0]  mem_data;
    logic        clear;
  } port_upd_t;

endpackage

// ===== src/psg_port_capture_frame_dump.sv =====
// Top level: sound register capture from CPU port writes with per-frame register dump.
// Port write: taken while idle, updates the register bank at the transfer edge, no result.
// Frame tick: the dump steps from IDLE through READ (registered read of the bank) to SEND,
//   which holds each byte until the sink takes it, then back to READ for the next entry;
//   after the sixteenth byte it returns to idle. One item at a time.
// Reset (rst_n low, synchronous): style undecided, select, latch and frame count zero,
//   frame limit 9000, all bank entries read as zero at once through per-entry valid bits.
`include "assert_macros.svh"

module psg_port_capture_frame_dump (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_port_high,
  input  logic [7:0]  in_port_low,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  output logic        out_done_res,
  output logic        out_latch_style
);

  psgcap_pkg::dump_state_t state_r, state_nxt;
  psgcap_pkg::port_style_t style_r;
  psgcap_pkg::port_upd_t   upd;

  logic [3:0]  sel_r;
  logic [7:0]  latch_r;
  logic [14:0] limit_r;
  logic [14:0] fcount_r;
  logic [14:0] fcount_nxt;
  logic        done_r;
  logic        latch_flag_r;
  logic [3:0]  idx_r, idx_nxt;

  // Register bank: one write port, one registered read port
  logic [7:0]  bank_mem [16];
  logic [15:0] bank_vld_r;
  logic [7:0]  rd_data_r;
  logic        rd_vld_r;

  logic in_xfer, out_xfer, port_xfer, tick_xfer, rd_en;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign port_xfer = in_xfer && !in_func;
  assign tick_xfer = in_xfer && in_func;

  // Decode the port write against the current style, select and latch
  psgcap_decode u_decode (
    .style      (style_r),
    .sel        (sel_r),
    .latch      (latch_r),
    .port_high  (in_port_high),
    .port_low   (in_port_low),
    .write_data (in_write_data),
    .upd        (upd)
  );

  // Saturating frame count; done compares the updated count
  always_comb begin
    fcount_nxt = (fcount_r < limit_r) ? fcount_r + 15'd1 : fcount_r;
  end

  // Dump sequencer: read an entry, then hold it on the output until the transfer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      psgcap_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (tick_xfer) begin
          idx_nxt   = '0;
          state_nxt = psgcap_pkg::FSM_READ;
        end
      end
      psgcap_pkg::FSM_READ: begin
        rd_en     = 1'b1;
        state_nxt = psgcap_pkg::FSM_SEND;
      end
      psgcap_pkg::FSM_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (idx_r == psgcap_pkg::DUMP_LAST) begin
            state_nxt = psgcap_pkg::FSM_IDLE;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            state_nxt = psgcap_pkg::FSM_READ;
          end
        end
      end
      default: begin
        state_nxt = psgcap_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psgcap_pkg::FSM_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Control state: style, select, latch, frame count, configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r      <= psgcap_pkg::STYLE_UNDECIDED;
      sel_r        <= '0;
      latch_r      <= '0;
      limit_r      <= psgcap_pkg::FRAME_LIMIT_RESET;
      fcount_r     <= '0;
      done_r       <= 1'b0;
      latch_flag_r <= 1'b0;
      bank_vld_r   <= '0;
    end else begin
      if (port_xfer) begin
        style_r <= upd.style;
        sel_r   <= upd.sel;
        latch_r <= upd.latch;
        if (upd.clear) begin
          bank_vld_r <= '0;
        end else if (upd.mem_we) begin
          bank_vld_r[upd.mem_addr] <= 1'b1;
        end
      end
      if (tick_xfer) begin
        fcount_r     <= fcount_nxt;
        done_r       <= (fcount_nxt >= limit_r);
        latch_flag_r <= (style_r == psgcap_pkg::STYLE_LATCH);
      end
      // Configuration must be written only while idle, so it never meets a transfer; the block does not enforce this
      if (cfg_we) begin
        case (cfg_index)
          psgcap_pkg::CFG_FORCE_LATCH: begin
            style_r <= cfg_data[0] ? psgcap_pkg::STYLE_LATCH : psgcap_pkg::STYLE_UNDECIDED;
          end
          psgcap_pkg::CFG_FRAME_LIMIT: begin
            limit_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Bank write: port writes happen only while idle, dump reads only outside idle,
  // so the read and write ports never touch the same entry in one cycle
  always_ff @(posedge clk) begin
    if (port_xfer && upd.mem_we) begin
      bank_mem[upd.mem_addr] <= upd.mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= bank_mem[idx_r];
    end
  end

  // Padding slots and never-written or cleared entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= bank_vld_r[idx_r] && (idx_r < psgcap_pkg::DUMP_REGS);
    end
  end

  assign out_frame_byte  = rd_vld_r ? rd_data_r : 8'h00;
  assign out_last_byte   = (idx_r == psgcap_pkg::DUMP_LAST);
  assign out_done_res    = done_r;
  assign out_latch_style = latch_flag_r;

  `ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid), "input taken while a dump byte is pending")
  `ASSERT_IMPLIES(a_tick_latency, tick_xfer, ##2 out_valid, "first dump byte late")
  `ASSERT_IMPLIES(a_pad_zero, out_valid && idx_r >= psgcap_pkg::DUMP_REGS, out_frame_byte == 8'h00, "padding byte not zero")
  `ASSERT_NEXT(a_last_ends, out_xfer && out_last_byte, in_ready, "dump did not end after last byte")

endmodule

// ===== src/psgcap_decode.sv =====
// Port write decoder: next style, select, latch and register bank write for one port write.
module psgcap_decode (
  input  psgcap_pkg::port_style_t style,
  input  logic [3:0]              sel,
  input  logic [7:0]              latch,
  input  logic [7:0]              port_high,
  input  logic [7:0]              port_low,
  input  logic [7:0]              write_data,
  output psgcap_pkg::port_upd_t   upd
);

  always_comb begin
    upd          = '0;
    upd.style    = style;
    upd.sel      = sel;
    upd.latch    = latch;
    upd.mem_addr = sel;
    upd.mem_data = write_data;

    // Single-port-pair decode
    if (style != psgcap_pkg::STYLE_LATCH && port_low == psgcap_pkg::PORT_LO_DATA) begin
      if (port_high == psgcap_pkg::PORT_HI_SELECT) begin
        upd.style = psgcap_pkg::STYLE_SINGLE;
        upd.sel   = write_data[3:0];
      end else if (port_high == psgcap_pkg::PORT_HI_WRITE) begin
        upd.style  = psgcap_pkg::STYLE_SINGLE;
        upd.mem_we = 1'b1;
      end else if (port_high[7:6] == psgcap_pkg::TOP_SELECT) begin
        upd.sel = write_data[3:0];
      end else if (port_high[7:6] == psgcap_pkg::TOP_WRITE) begin
        upd.mem_we = 1'b1;
      end
    end else if (style != psgcap_pkg::STYLE_LATCH &&
                 port_low == psgcap_pkg::PORT_LO_LOCK) begin
      upd.style = psgcap_pkg::STYLE_SINGLE;
    end

    // Latch-plus-control decode, seen after the step above
    if (upd.style != psgcap_pkg::STYLE_SINGLE) begin
      if (port_high == psgcap_pkg::PORT_HI_CTRL) begin
        if (write_data[7:6] == psgcap_pkg::TOP_WRITE) begin
          upd.mem_we   = 1'b1;
          upd.mem_addr = upd.sel;
          upd.mem_data = latch;
        end else if (write_data[7:6] == psgcap_pkg::TOP_SELECT) begin
          upd.sel = latch[3:0];
        end
      end else if (port_high == psgcap_pkg::PORT_HI_LATCH) begin
        upd.latch = write_data;
        if (upd.style == psgcap_pkg::STYLE_UNDECIDED) begin
          upd.style = psgcap_pkg::STYLE_LATCH;
          upd.clear = 1'b1;
        end
      end
    end
  end

endmodule

// ===== sim/psg_port_capture_frame_dump_tb.sv =====
// Self-checking testbench for the sound register capture and frame dump block.
`timescale 1ns / 1ps

module psg_port_capture_frame_dump_tb;

  // Item kinds on the input channel
  localparam logic FUNC_PORT_WRITE = 1'b0;
  localparam logic FUNC_FRAME_TICK = 1'b1;

  // Cycles to let pass after the last frame byte before touching the
  // registers or ending the run.
  localparam int SETTLE_CYCLES = 40;
  localparam int SINK_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic       func;
    logic [7:0] port_high;
    logic [7:0] port_low;
    logic [7:0] data;
  } port_op_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
    logic       latch;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = psgcap_pkg::CFG_FORCE_LATCH;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FUNC_PORT_WRITE;
  logic [7:0]  in_port_high = '0;
  logic [7:0]  in_port_low = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;
  logic        out_done_res;
  logic        out_latch_style;

  psg_port_capture_frame_dump i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_port_high   (in_port_high),
    .in_port_low    (in_port_low),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_done_res   (out_done_res),
    .out_latch_style(out_latch_style)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the capture state, advanced on every accepted transfer
  psgcap_pkg::port_style_t cap_style = psgcap_pkg::STYLE_UNDECIDED;
  logic [3:0]  cap_sel = '0;
  logic [7:0]  cap_latch = '0;
  logic [7:0]  cap_regs [16];
  logic [14:0] frames_counted = '0;
  logic [14:0] limit_setting = psgcap_pkg::FRAME_LIMIT_RESET;

  port_op_t    pending_ops [$];
  frame_byte_t frame_bytes_due [$];
  int          items_queued = 0;
  int          items_taken = 0;
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          in_gap = 0;
  int          sink_stall = 0;
  int          sink_hold = 0;

  initial begin
    foreach (cap_regs[i]) cap_regs[i] = 8'h00;
  end

  // Decode one CPU port write into the register bank, the single-port-pair
  // machine first and then the latch/control-port machine.
  task automatic apply_port_write(input logic [7:0] hi, input logic [7:0] lo,
                                  input logic [7:0] d);
    if (cap_style != psgcap_pkg::STYLE_LATCH && lo == psgcap_pkg::PORT_LO_DATA) begin
      if (hi == psgcap_pkg::PORT_HI_SELECT) begin
        cap_style = psgcap_pkg::STYLE_SINGLE;
        cap_sel = d[3:0];
      end else if (hi == psgcap_pkg::PORT_HI_WRITE) begin
        cap_style = psgcap_pkg::STYLE_SINGLE;
        cap_regs[cap_sel] = d;
      end else if (hi[7:6] == psgcap_pkg::TOP_SELECT) begin
        cap_sel = d[3:0];
      end else if (hi[7:6] == psgcap_pkg::TOP_WRITE) begin
        cap_regs[cap_sel] = d;
      end
    end else if (cap_style != psgcap_pkg::STYLE_LATCH && lo == psgcap_pkg::PORT_LO_LOCK) begin
      cap_style = psgcap_pkg::STYLE_SINGLE;
    end

    if (cap_style != psgcap_pkg::STYLE_SINGLE) begin
      if (hi == psgcap_pkg::PORT_HI_CTRL) begin
        if (d[7:6] == psgcap_pkg::TOP_WRITE) cap_regs[cap_sel] = cap_latch;
        else if (d[7:6] == psgcap_pkg::TOP_SELECT) cap_sel = cap_latch[3:0];
      end else if (hi == psgcap_pkg::PORT_HI_LATCH) begin
        cap_latch = d;
        // first latch write while undecided switches style and wipes the bank
        if (cap_style == psgcap_pkg::STYLE_UNDECIDED) begin
          cap_style = psgcap_pkg::STYLE_LATCH;
          foreach (cap_regs[i]) cap_regs[i] = 8'h00;
        end
      end
    end
  endtask

  // Count the frame (saturating at the limit) and queue its sixteen bytes.
  task automatic predict_frame_dump();
    frame_byte_t fb;
    if (frames_counted < limit_setting) frames_counted = frames_counted + 15'd1;
    for (int k = 0; k < 16; k++) begin
      fb.value = (k < psgcap_pkg::DUMP_REGS) ? cap_regs[k] : 8'h00;
      fb.last  = (k == psgcap_pkg::DUMP_LAST);
      fb.done  = (frames_counted >= limit_setting);
      fb.latch = (cap_style == psgcap_pkg::STYLE_LATCH);
      frame_bytes_due.push_back(fb);
    end
  endtask

  task automatic push_op(input logic f, input logic [7:0] hi, input logic [7:0] lo,
                         input logic [7:0] d);
    port_op_t op;
    op.func = f;
    op.port_high = hi;
    op.port_low = lo;
    op.data = d;
    pending_ops.push_back(op);
    items_queued++;
  endtask

  // Mostly well-formed decode traffic with random payload, some frame ticks,
  // and a share of pure noise.
  task automatic queue_random_ops(input int count);
    int r;
    logic f;
    logic [7:0] hi, lo, d;
    repeat (count) begin
      r = $urandom_range(0, 99);
      f = FUNC_PORT_WRITE;
      hi = 8'($urandom);
      lo = 8'($urandom);
      d = 8'($urandom);
      if (r < 33) begin
        f = FUNC_FRAME_TICK;
      end else if (r < 43) begin
        lo = psgcap_pkg::PORT_LO_DATA;
        hi = psgcap_pkg::PORT_HI_SELECT;
      end else if (r < 53) begin
        lo = psgcap_pkg::PORT_LO_DATA;
        hi = psgcap_pkg::PORT_HI_WRITE;
      end else if (r < 60) begin
        lo = psgcap_pkg::PORT_LO_DATA;
        hi[7:6] = $urandom_range(0, 1) ? psgcap_pkg::TOP_SELECT : psgcap_pkg::TOP_WRITE;
      end else if (r < 63) begin
        lo = psgcap_pkg::PORT_LO_LOCK;
      end else if (r < 75) begin
        hi = psgcap_pkg::PORT_HI_LATCH;
      end else if (r < 90) begin
        hi = psgcap_pkg::PORT_HI_CTRL;
        d[7:6] = $urandom_range(0, 3) != 0 ?
                 ($urandom_range(0, 1) ? psgcap_pkg::TOP_SELECT : psgcap_pkg::TOP_WRITE)
                 : d[7:6];
      end else begin
        f = 1'($urandom_range(0, 1));
      end
      push_op(f, hi, lo, d);
    end
  endtask

  // Registers change only with the block idle, so the shadow copy follows at once.
  task automatic write_register(input logic idx, input logic [14:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == psgcap_pkg::CFG_FORCE_LATCH) begin
      cap_style = value[0] ? psgcap_pkg::STYLE_LATCH : psgcap_pkg::STYLE_UNDECIDED;
    end else begin
      limit_setting = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every queued item to be taken and every frame byte to arrive,
  // then give the block time to fall back to idle.
  task automatic wait_drained();
    int waited = 0;
    while ((items_taken != items_queued || frame_bytes_due.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (frame_bytes_due.size() != 0) begin
      $display("%0t: %0d expected frame bytes never arrived", $time,
               frame_bytes_due.size());
      errors++;
      frame_bytes_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Driver: advance through the pending queue, hold the payload until the
  // transfer, and insert random gaps while idling is on.
  always @(posedge clk) begin
    port_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_func == FUNC_FRAME_TICK) predict_frame_dump();
        else apply_port_write(in_port_high, in_port_low, in_write_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          op = pending_ops.pop_front();
          in_func <= op.func;
          in_port_high <= op.port_high;
          in_port_low <= op.port_low;
          in_write_data <= op.data;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare each frame byte with the oldest expectation, then
  // decide the sink's readiness for the next cycle.
  always @(posedge clk) begin
    frame_byte_t fb;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame byte, expected none, actual %0h", $time,
                   out_frame_byte);
        end else begin
          fb = frame_bytes_due.pop_front();
          check_field("frame_byte", fb.value, out_frame_byte);
          check_field("last_byte", 8'(fb.last), 8'(out_last_byte));
          check_field("done_res", 8'(fb.done), 8'(out_done_res));
          check_field("latch_style", 8'(fb.latch), 8'(out_latch_style));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        sink_hold = SINK_HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset settings, undecided style: non-locking select/write, then the
    // first latch write switches style and clears the bank.
    push_op(FUNC_FRAME_TICK, 8'h00, 8'h00, 8'h00);
    push_op(FUNC_PORT_WRITE, 8'hc5, psgcap_pkg::PORT_LO_DATA, 8'h07);
    push_op(FUNC_PORT_WRITE, 8'h85, psgcap_pkg::PORT_LO_DATA, 8'ha5);
    push_op(FUNC_PORT_WRITE, 8'h40, psgcap_pkg::PORT_LO_DATA, 8'h11);
    push_op(FUNC_FRAME_TICK, 8'hff, 8'hff, 8'hff);
    // select by top bits and latch load from one write
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_LATCH, psgcap_pkg::PORT_LO_DATA, 8'h3c);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_LATCH, 8'hff, 8'h09);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_CTRL, 8'h00, 8'hc0);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_LATCH, psgcap_pkg::PORT_LO_DATA, 8'hff);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_CTRL, 8'h00, 8'h80);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_CTRL, 8'h00, 8'h3f);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_CTRL, 8'h00, 8'h7f);
    // single-pair ports are dead in latch style
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_SELECT, psgcap_pkg::PORT_LO_DATA, 8'h02);
    push_op(FUNC_FRAME_TICK, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Back to undecided without touching the bank; lock single style via the
    // lock port, after which the latch ports are ignored.
    write_register(psgcap_pkg::CFG_FORCE_LATCH, 15'd0);
    write_register(psgcap_pkg::CFG_FRAME_LIMIT, 15'd50);
    push_op(FUNC_PORT_WRITE, 8'h00, psgcap_pkg::PORT_LO_LOCK, 8'h00);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_LATCH, 8'h00, 8'h55);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_SELECT, psgcap_pkg::PORT_LO_DATA, 8'hfd);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_WRITE, psgcap_pkg::PORT_LO_DATA, 8'hff);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_SELECT, psgcap_pkg::PORT_LO_DATA, 8'h00);
    push_op(FUNC_PORT_WRITE, 8'h80, psgcap_pkg::PORT_LO_DATA, 8'h81);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_SELECT, psgcap_pkg::PORT_LO_DATA, 8'hfe);
    push_op(FUNC_PORT_WRITE, psgcap_pkg::PORT_HI_WRITE, psgcap_pkg::PORT_LO_DATA, 8'h5a);
    push_op(FUNC_FRAME_TICK, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Forced latch style, limit 30000; hold off the sink for a long
    // stretch so the block fills and stalls its input.
    write_register(psgcap_pkg::CFG_FORCE_LATCH, 15'd1);
    write_register(psgcap_pkg::CFG_FRAME_LIMIT, 15'd30000);
    queue_random_ops(50);
    hold_requests++;
    wait_drained();

    // Undecided start, limit 50, at which the frame count saturates.
    write_register(psgcap_pkg::CFG_FORCE_LATCH, 15'd0);
    write_register(psgcap_pkg::CFG_FRAME_LIMIT, 15'd50);
    queue_random_ops(50);
    wait_drained();

    // Raise the limit again so counting resumes.
    write_register(psgcap_pkg::CFG_FORCE_LATCH, 15'd1);
    write_register(psgcap_pkg::CFG_FRAME_LIMIT, 15'($urandom_range(16384, 30000)));
    queue_random_ops(50);
    wait_drained();

    // Drop the limit under the count: done shows from the next frame tick. No idling here.
    idle_on = 1'b0;
    write_register(psgcap_pkg::CFG_FORCE_LATCH, 15'd0);
    write_register(psgcap_pkg::CFG_FRAME_LIMIT, 15'd50);
    queue_random_ops(50);
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 300000);
    $display("FAIL");
    $finish;
  end

endmodule
